[hdl/lca_pkg.sv]
// shared constants, segment descriptor type and amplitude table builder
package lca_pkg;

  localparam int COORD_FRACTION_BITS = 4;
  localparam int AMPLITUDE_BITS      = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_X         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_Y         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEEP_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_DISTANCE = 3'd5;

  localparam logic [15:0] STEEP_LIMIT_RESET = 16'd16384;
  localparam logic [15:0] CUTOFF_RESET      = 16'd333;

  localparam int ROOT_W = 27;

  // segment quantities derived once per configuration
  typedef struct packed {
    logic signed [15:0]  sx;
    logic signed [15:0]  sy;
    logic signed [15:0]  ex;
    logic signed [15:0]  ey;
    logic [15:0]         dx;
    logic signed [16:0]  dy;
    logic                neg;
    logic                steep;
    logic [ROOT_W-1:0]   root;
    logic [15:0]         cutoff;
  } seg_t;

  // distances above this give amplitude 0 anyway (3*d^3 reaches 12 in Q24)
  localparam int AMP_IDX_W     = 9;
  localparam int AMP_ROM_DEPTH = 1 << AMP_IDX_W;

  typedef logic [AMP_ROM_DEPTH-1:0][AMPLITUDE_BITS-1:0] amp_rom_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // exp(-f) in Q30, f in Q24 up to 1.0, alternating series of 17 terms
  function automatic logic [63:0] exp_neg_frac(logic [63:0] f);
    logic [63:0] t;
    longint      s;
    t = Q30_ONE;
    s = longint'(Q30_ONE);
    t = ((t * f) >> 24) / 1;  s = s - longint'(t);
    t = ((t * f) >> 24) / 2;  s = s + longint'(t);
    t = ((t * f) >> 24) / 3;  s = s - longint'(t);
    t = ((t * f) >> 24) / 4;  s = s + longint'(t);
    t = ((t * f) >> 24) / 5;  s = s - longint'(t);
    t = ((t * f) >> 24) / 6;  s = s + longint'(t);
    t = ((t * f) >> 24) / 7;  s = s - longint'(t);
    t = ((t * f) >> 24) / 8;  s = s + longint'(t);
    t = ((t * f) >> 24) / 9;  s = s - longint'(t);
    t = ((t * f) >> 24) / 10; s = s + longint'(t);
    t = ((t * f) >> 24) / 11; s = s - longint'(t);
    t = ((t * f) >> 24) / 12; s = s + longint'(t);
    t = ((t * f) >> 24) / 13; s = s - longint'(t);
    t = ((t * f) >> 24) / 14; s = s + longint'(t);
    t = ((t * f) >> 24) / 15; s = s - longint'(t);
    t = ((t * f) >> 24) / 16; s = s + longint'(t);
    if (s < 0) s = 0;
    return 64'(s);
  endfunction

  // amplitude of one Q8.8 distance, cutoff not applied
  function automatic logic [AMPLITUDE_BITS-1:0] amp_of(logic [63:0] d);
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] e;
    logic [63:0] e1;
    logic [63:0] a;
    logic [63:0] amax;
    amax = (64'd1 << AMPLITUDE_BITS) - 64'd1;
    x = 64'd3 * d * d * d;
    n = x >> 24;
    if (n >= 64'd12) return '0;
    e  = exp_neg_frac(x & 64'hFF_FFFF);
    e1 = exp_neg_frac(64'd1 << 24);
    for (int i = 0; i < 12; i++) begin
      if (64'(i) < n) e = (e * e1) >> 30;
    end
    a = ((e << AMPLITUDE_BITS) + (64'd1 << 29)) >> 30;
    if (a > amax) a = amax;
    return a[AMPLITUDE_BITS-1:0];
  endfunction

  function automatic amp_rom_t amp_rom();
    amp_rom_t r;
    for (int d = 0; d < AMP_ROM_DEPTH; d++) begin
      r[d] = amp_of(64'(d));
    end
    return r;
  endfunction

endpackage

[hdl/lca_setup.sv]
// configuration registers and segment setup sequencer with bit-serial square root
module lca_setup (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lca_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lca_pkg::seg_t                  seg_o,
  output logic                           busy_o
);
  import lca_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_PROD, ST_ROOT} state_e;

  logic signed [15:0] first_x_q, first_y_q, second_x_q, second_y_q;
  logic [23:0]        steep_limit_q;
  logic [15:0]        cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q     <= '0;
      first_y_q     <= '0;
      second_x_q    <= '0;
      second_y_q    <= '0;
      steep_limit_q <= 24'(STEEP_LIMIT_RESET);
      cutoff_q      <= CUTOFF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIRST_X:         first_x_q     <= cfg_data_i[15:0];
        CFG_FIRST_Y:         first_y_q     <= cfg_data_i[15:0];
        CFG_SECOND_X:        second_x_q    <= cfg_data_i[15:0];
        CFG_SECOND_Y:        second_y_q    <= cfg_data_i[15:0];
        CFG_STEEP_LIMIT:     steep_limit_q <= cfg_data_i;
        CFG_CUTOFF_DISTANCE: cutoff_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // endpoint ordering: smaller x first, smaller y on equal x
  logic               swap;
  logic signed [15:0] osx, osy, oex, oey;
  logic signed [16:0] dxw, dyw;

  always_comb begin
    if (first_x_q == second_x_q) swap = second_y_q < first_y_q;
    else                         swap = second_x_q < first_x_q;
    osx = swap ? second_x_q : first_x_q;
    osy = swap ? second_y_q : first_y_q;
    oex = swap ? first_x_q  : second_x_q;
    oey = swap ? first_y_q  : second_y_q;
    dxw = {oex[15], oex} - {osx[15], osx};
    dyw = {oey[15], oey} - {osy[15], osy};
  end

  state_e             state_q;
  logic signed [15:0] sx_q, sy_q, ex_q, ey_q;
  logic [15:0]        dx_q;
  logic signed [16:0] dy_q;
  logic [15:0]        ady_q;
  logic               neg_q, steep_q;
  logic [53:0]        rad_q;
  logic [28:0]        rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [4:0]         cnt_q;

  logic [32:0]        len2;
  logic signed [41:0] slope_lhs, slope_rhs;
  logic [30:0]        rem_t, trial;

  always_comb begin
    len2      = 33'(dx_q * dx_q) + 33'(ady_q * ady_q);
    slope_lhs = {{17{dy_q[16]}}, dy_q, 8'b0};
    slope_rhs = $signed({2'b0, 40'(steep_limit_q * dx_q)});
    rem_t     = {rem_q, rad_q[53:52]};
    trial     = {2'b0, root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      state_q <= ST_LOAD;
    end else begin
      unique case (state_q)
        ST_IDLE: ;
        ST_LOAD: begin
          sx_q    <= osx;
          sy_q    <= osy;
          ex_q    <= oex;
          ey_q    <= oey;
          dx_q    <= dxw[15:0];
          dy_q    <= dyw;
          ady_q   <= dyw[16] ? 16'(-dyw) : dyw[15:0];
          neg_q   <= (dxw != '0) && dyw[16];
          state_q <= ST_PROD;
        end
        ST_PROD: begin
          rad_q   <= {1'b0, len2, 20'b0};
          steep_q <= (dx_q == '0) || (slope_lhs > slope_rhs);
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= 5'(ROOT_W - 1);
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          rad_q <= {rad_q[51:0], 2'b00};
          if (rem_t >= trial) begin
            rem_q  <= 29'(rem_t - trial);
            root_q <= {root_q[ROOT_W-2:0], 1'b1};
          end else begin
            rem_q  <= rem_t[28:0];
            root_q <= {root_q[ROOT_W-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) state_q <= ST_IDLE;
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  always_comb begin
    seg_o.sx     = sx_q;
    seg_o.sy     = sy_q;
    seg_o.ex     = ex_q;
    seg_o.ey     = ey_q;
    seg_o.dx     = dx_q;
    seg_o.dy     = dy_q;
    seg_o.neg    = neg_q;
    seg_o.steep  = steep_q;
    seg_o.root   = root_q;
    seg_o.cutoff = cutoff_q;
    busy_o       = state_q != ST_IDLE;
  end

endmodule

[hdl/line_coverage_amplitude_unit.sv]
// per-pixel coverage amplitude pipeline against one configured segment
//
//  channel | signals                                  | transfer
//  --------+------------------------------------------+---------------------------
//  pixel   | in_valid_i in_ready_o pixel_x_i pixel_y_i | in_valid_i & in_ready_o
//  result  | out_valid_o out_ready_i amplitude_o      | out_valid_o & out_ready_i
//          | distance_o                               |
//  config  | cfg_we_i cfg_index_i cfg_data_i          | cfg_we_i
//
// one pixel per cycle unless stalled or in segment setup, through three setup stages,
// eight stages of two quotient bits each for the perpendicular divide, one table stage.
// each stage holds its item while the next is full, so bubbles close up under stall.
// after reset and after every configuration write the segment setup (ordering, products,
// 27-step square root) runs with in_ready_o low.
module line_coverage_amplitude_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [15:0]                  pixel_x_i,
  input  logic signed [15:0]                  pixel_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lca_pkg::AMPLITUDE_BITS-1:0]  amplitude_o,
  output logic [15:0]                         distance_o,
  input  logic                                cfg_we_i,
  input  logic [lca_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lca_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import lca_pkg::*;

  localparam int DIV_STAGES = 8;
  localparam int NUM_W      = 35;
  localparam int NSH        = 18 - COORD_FRACTION_BITS;
  localparam int R0_W       = NUM_W + NSH - 16;
  localparam int Q88_SH     = 8 - COORD_FRACTION_BITS;
  localparam amp_rom_t AMP_ROM = amp_rom();

  typedef enum logic [2:0] {K_FAR, K_END, K_START, K_STEEP, K_PERP} kind_e;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [15:0]       nb;
    logic [15:0]       q;
    logic              sat;
    logic              perp;
    logic [15:0]       dsim;
  } div_t;

  function automatic logic [16:0] mag17(logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic [15:0] to_q88(logic [17:0] c);
    logic [25:0] v;
    v = 26'(c) << Q88_SH;
    return (v[25:16] != '0) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic div_t div_step(div_t s, logic [ROOT_W-1:0] root);
    div_t        r;
    logic [ROOT_W:0] t;
    r = s;
    for (int i = 0; i < 2; i++) begin
      t    = {r.rem, r.nb[15]};
      r.nb = {r.nb[14:0], 1'b0};
      if (t >= {1'b0, root}) begin
        t   = t - {1'b0, root};
        r.q = {r.q[14:0], 1'b1};
      end else begin
        r.q = {r.q[14:0], 1'b0};
      end
      r.rem = t[ROOT_W-1:0];
    end
    return r;
  endfunction

  seg_t seg;
  logic busy;

  lca_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .seg_o       (seg),
    .busy_o      (busy)
  );

  // valid bits and ready chain
  logic                  v1_q, v2_q, v3_q, vo_q;
  logic [DIV_STAGES-1:0] dv_q;
  logic                  rdy1, rdy2, rdy3, rdyo;
  logic [DIV_STAGES-1:0] rdyd;
  logic                  in_fire;

  always_comb begin
    rdyo = ~vo_q | out_ready_i;
    rdyd[DIV_STAGES-1] = ~dv_q[DIV_STAGES-1] | rdyo;
    for (int j = DIV_STAGES - 2; j >= 0; j--) rdyd[j] = ~dv_q[j] | rdyd[j+1];
    rdy3 = ~v3_q | rdyd[0];
    rdy2 = ~v2_q | rdy3;
    rdy1 = ~v1_q | rdy2;
    in_ready_o = rdy1 & ~busy & ~cfg_we_i;
    in_fire    = in_valid_i & in_ready_o;
  end

  // stage 1: offsets to both ends and region of the pixel
  logic signed [16:0] dex, dey, dsx, dsy;
  logic               end_side, start_side;
  kind_e              kind;

  always_comb begin
    dex = {pixel_x_i[15], pixel_x_i} - {seg.ex[15], seg.ex};
    dey = {pixel_y_i[15], pixel_y_i} - {seg.ey[15], seg.ey};
    dsx = {pixel_x_i[15], pixel_x_i} - {seg.sx[15], seg.sx};
    dsy = {pixel_y_i[15], pixel_y_i} - {seg.sy[15], seg.sy};
    end_side   = seg.neg ? (pixel_y_i < seg.ey) : (pixel_y_i > seg.ey);
    start_side = seg.neg ? (pixel_y_i > seg.sy) : (pixel_y_i < seg.sy);
    if ((pixel_x_i > seg.ex && end_side) || (pixel_x_i < seg.sx && start_side)) kind = K_FAR;
    else if (end_side)   kind = K_END;
    else if (start_side) kind = K_START;
    else if (seg.steep)  kind = K_STEEP;
    else                 kind = K_PERP;
  end

  kind_e              kind1_q;
  logic signed [16:0] dex1_q, dey1_q, dsx1_q, dsy1_q;

  // stage 2: coordinate distances and the two cross products
  logic [15:0]        dsim;
  logic signed [33:0] prod_a, prod_b;

  always_comb begin
    case (kind1_q)
      K_FAR:   dsim = 16'd512;
      K_END:   dsim = to_q88(18'(mag17(dex1_q)) + 18'(mag17(dey1_q)));
      K_START: dsim = to_q88(18'(mag17(dsx1_q)) + 18'(mag17(dsy1_q)));
      K_STEEP: dsim = to_q88(18'(mag17(dsx1_q)));
      default: dsim = '0;
    endcase
    prod_a = -(dsy1_q * $signed({1'b0, seg.dx}));
    prod_b = seg.dy * dsx1_q;
  end

  logic               perp2_q;
  logic [15:0]        dsim2_q;
  logic signed [33:0] pa2_q, pb2_q;

  // stage 3: numerator magnitude, saturation test, first partial remainder
  logic signed [NUM_W-1:0] nsum;
  logic [NUM_W-1:0]        num;
  logic [NUM_W+NSH-1:0]    nfull;
  div_t                    st3;

  always_comb begin
    nsum  = {pa2_q[33], pa2_q} + {pb2_q[33], pb2_q};
    num   = nsum[NUM_W-1] ? NUM_W'(-nsum) : NUM_W'(nsum);
    nfull = {num, NSH'(0)};
    st3.rem  = nfull[16 +: ROOT_W];
    st3.nb   = nfull[15:0];
    st3.q    = '0;
    st3.sat  = nfull[NUM_W+NSH-1:16] >= R0_W'(seg.root);
    st3.perp = perp2_q;
    st3.dsim = dsim2_q;
  end

  div_t st3_q;
  div_t dst_q [DIV_STAGES];
  div_t din   [DIV_STAGES];
  logic [DIV_STAGES-1:0] dvin;

  always_comb begin
    din[0]  = st3_q;
    dvin[0] = v3_q;
    for (int j = 1; j < DIV_STAGES; j++) begin
      din[j]  = dst_q[j-1];
      dvin[j] = dv_q[j-1];
    end
  end

  // final distance and amplitude table
  div_t        dl;
  logic [15:0] dfin;

  always_comb begin
    dl   = dst_q[DIV_STAGES-1];
    dfin = dl.perp ? (dl.sat ? 16'hFFFF : dl.q) : dl.dsim;
  end

  logic [AMPLITUDE_BITS-1:0] amp_q;
  logic [15:0]               dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      dv_q <= '0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_fire;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      for (int j = 0; j < DIV_STAGES; j++) begin
        if (rdyd[j]) dv_q[j] <= dvin[j];
      end
      if (rdyo) vo_q <= dv_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      kind1_q <= kind;
      dex1_q  <= dex;
      dey1_q  <= dey;
      dsx1_q  <= dsx;
      dsy1_q  <= dsy;
    end
    if (rdy2) begin
      perp2_q <= kind1_q == K_PERP;
      dsim2_q <= dsim;
      pa2_q   <= prod_a;
      pb2_q   <= prod_b;
    end
    if (rdy3) st3_q <= st3;
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (rdyd[j]) dst_q[j] <= div_step(din[j], seg.root);
    end
    if (rdyo) begin
      dist_q <= dfin;
      if (dfin > seg.cutoff || dfin[15:AMP_IDX_W] != '0) amp_q <= '0;
      else amp_q <= AMP_ROM[dfin[AMP_IDX_W-1:0]];
    end
  end

  assign out_valid_o = vo_q;
  assign amplitude_o = amp_q;
  assign distance_o  = dist_q;

  a_no_accept_in_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("item accepted during segment setup");

  a_amp_within_cutoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && amplitude_o != '0) |-> (distance_o <= seg.cutoff))
    else $error("nonzero amplitude beyond cutoff");

  a_zero_dist_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && distance_o == '0) |-> (amplitude_o == '1))
    else $error("zero distance without full amplitude");

endmodule
